>>> sv/svt_pkg.sv
// svt_pkg: shared types and codes of the sorted value table
// no dependencies; imported by sorted_value_table_top

package svt_pkg;

	localparam int SVT_DEPTH = 16;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_SEARCH = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic        [1:0]  req_type;
		logic signed [31:0] item_value;
	} svt_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [3:0] position;
		logic [4:0] count;
	} svt_rsp_t;

endpackage

>>> sv/sorted_value_table_top.sv
// sorted_value_table_top: bounded ascending table of signed 32-bit values
// depends on svt_pkg (types, codes) and svt_ram (entry store)
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  req     | in        | req_valid/req_stall| req_type, item_value
//  rsp     | out       | rsp_valid/rsp_stall| status, found, position, count
//
// one request at a time; the entries are walked one per cycle through the
// single read port of the entry ram (registered read)
// insert walks down from the top, shifting each larger entry up; a full or
//   empty table needs no walk
// remove walks up to the hit and then shifts the entries above it down;
//   search stops at the hit or after the last entry; empty table: no walk
// reset clears the count and the control state only; the ram is not cleared
// a stalled response holds the block in its final cycle; the next request is
// taken once the response has moved into the output register

module sorted_value_table_top #(
	parameter int DEPTH = svt_pkg::SVT_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  svt_pkg::svt_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output svt_pkg::svt_rsp_t rsp
);

	import svt_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_PUT  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	// control state
	state_t  state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          hit_q, hit_d;
	logic          rsp_valid_q;

	// request and result payload
	logic        [1:0]    op_q, op_d;
	logic signed [31:0]   val_q, val_d;
	logic        [IW-1:0] idx_q, idx_d;
	logic        [1:0]    status_q, status_d;
	logic                 found_q, found_d;
	logic        [IW-1:0] pos_q, pos_d;
	svt_rsp_t             rsp_q;

	// ram port
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic [IW-1:0] rd_addr;
	logic [31:0]   rd_data;

	logic [CW-1:0] cnt_m1;
	logic [IW-1:0] last_idx;
	logic          at_last;
	logic          entry_lt;
	logic          entry_eq;
	logic          rsp_load;

	svt_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_entries (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cnt_m1   = count_q - CW'(1);
	assign last_idx = cnt_m1[IW-1:0];
	assign at_last  = (idx_q == last_idx);
	// signed order of the stored entry against the request value
	assign entry_lt = ($signed(rd_data) < val_q);
	assign entry_eq = (rd_data == val_q);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_load  = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		hit_d    = hit_q;
		op_d     = op_q;
		val_d    = val_q;
		idx_d    = idx_q;
		status_d = status_q;
		found_d  = found_q;
		pos_d    = pos_q;
		rd_addr  = idx_q;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = rd_data;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_d     = req.req_type;
					val_d    = req.item_value;
					hit_d    = 1'b0;
					status_d = ST_OK;
					found_d  = 1'b0;
					pos_d    = '0;
					state_d  = S_FIN;
					case (req.req_type)
						REQ_INSERT: begin
							if (count_q == CW'(DEPTH)) begin
								status_d = ST_FULL;
							end else if (count_q == '0) begin
								// empty table: straight into index 0
								wr_en   = 1'b1;
								wr_addr = '0;
								wr_data = req.item_value;
								count_d = count_q + CW'(1);
							end else begin
								// walk down from the top, shifting up
								idx_d   = last_idx;
								rd_addr = last_idx;
								state_d = S_SCAN;
							end
						end
						REQ_REMOVE, REQ_SEARCH: begin
							if (count_q == '0) begin
								status_d = ST_NOT_FOUND;
							end else begin
								idx_d   = '0;
								rd_addr = '0;
								state_d = S_SCAN;
							end
						end
						default: begin
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (op_q == REQ_INSERT) begin
					wr_en   = 1'b1;
					wr_addr = idx_q + IW'(1);
					if (entry_lt) begin
						// first smaller entry found: new value goes above it
						wr_data = val_q;
						pos_d   = idx_q + IW'(1);
						count_d = count_q + CW'(1);
						state_d = S_FIN;
					end else if (idx_q == '0) begin
						state_d = S_PUT;
					end else begin
						idx_d   = idx_q - IW'(1);
						rd_addr = idx_q - IW'(1);
					end
				end else if (hit_q) begin
					// close the gap: move each entry down by one
					wr_en   = 1'b1;
					wr_addr = idx_q - IW'(1);
					if (at_last) begin
						count_d = count_q - CW'(1);
						state_d = S_FIN;
					end else begin
						idx_d   = idx_q + IW'(1);
						rd_addr = idx_q + IW'(1);
					end
				end else if (entry_eq) begin
					found_d = 1'b1;
					pos_d   = idx_q;
					if (op_q == REQ_SEARCH) begin
						state_d = S_FIN;
					end else if (at_last) begin
						count_d = count_q - CW'(1);
						state_d = S_FIN;
					end else begin
						hit_d   = 1'b1;
						idx_d   = idx_q + IW'(1);
						rd_addr = idx_q + IW'(1);
					end
				end else if (at_last) begin
					status_d = ST_NOT_FOUND;
					state_d  = S_FIN;
				end else begin
					idx_d   = idx_q + IW'(1);
					rd_addr = idx_q + IW'(1);
				end
			end
			S_PUT: begin
				// every stored entry was shifted up: new value at the bottom
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = val_q;
				pos_d   = '0;
				count_d = count_q + CW'(1);
				state_d = S_FIN;
			end
			S_FIN: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			hit_q   <= hit_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		val_q    <= val_d;
		idx_q    <= idx_d;
		status_q <= status_d;
		found_q  <= found_d;
		pos_q    <= pos_d;
		if (rsp_load) begin
			rsp_q.status   <= status_q;
			rsp_q.found    <= found_q;
			rsp_q.position <= 4'(pos_q);
			rsp_q.count    <= 5'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above table size");

	// the count moves by at most one per request
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == CW'($past(count_q) + CW'(1)) ||
			 count_q == CW'($past(count_q) - CW'(1))))
		else $error("entry count jumped");

	// the walk never writes the entry it is reading in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && wr_en |-> wr_addr != rd_addr)
		else $error("ram read and write collide during walk");

	// the shift phase belongs to a remove only
	a_hit_remove: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q && (state_q == S_SCAN) |-> op_q == REQ_REMOVE)
		else $error("shift phase outside remove");

endmodule

>>> sv/svt_ram.sv
// svt_ram: generic single-clock ram, one write and one read port
// registered read data; no package needed

module svt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
